/* hdl/eibd_pkg.sv */
`default_nettype none
package eibd_pkg;

	// build-time defaults
	localparam int MAX_BITS_DEF  = 1024;
	localparam int TIME_BITS_DEF = 32;
	localparam int QUEUE_DEPTH   = 2;

	// fixed field widths
	localparam int IN_TIME_W  = 32;
	localparam int OUT_TIME_W = 32;
	localparam int TOL_W      = 8;
	localparam int END_W      = 10;
	localparam int CFG_W      = 10;
	localparam int CFG_IDX_W  = 1;
	localparam int STATUS_W   = 3;
	localparam int IDX_W      = 10;
	// deviation scale of one hundred needs seven extra bits
	localparam int DEV_EXTRA_W = 7;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(25);
	localparam logic [END_W-1:0] END_RESET = END_W'(300);

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE = 3'd0,
		ST_END  = 3'd1,
		ST_BAD  = 3'd2,
		ST_OK   = 3'd3,
		ST_FULL = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOLERANCE = 1'd0,
		REG_END       = 1'd1
	} cfg_reg_t;

	// queue flags seen by the front and back parts
	typedef struct packed {
		logic full;
		logic not_empty;
	} q_status_t;

endpackage
`default_nettype wire

/* hdl/eibd_front.sv */
`default_nettype none
module eibd_front #(
	parameter int TIME_BITS = eibd_pkg::TIME_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire                              edge_level,
	input  wire  [eibd_pkg::IN_TIME_W-1:0]   edge_time,
	input  wire  eibd_pkg::q_status_t        q_stat,
	output logic                             push,
	output logic                             push_level,
	output logic [TIME_BITS-1:0]             push_now
);

	logic                                  valid_s1;
	logic                                  level_s1;
	logic [TIME_BITS-1:0]                  now_s1;
	logic [TIME_BITS+eibd_pkg::IN_TIME_W-1:0] time_ext;

	// timestamps live modulo 2^TIME_BITS
	assign time_ext = (TIME_BITS + eibd_pkg::IN_TIME_W)'(edge_time);

	assign in_stall   = valid_s1 & q_stat.full;
	assign push       = valid_s1 & ~q_stat.full;
	assign push_level = level_s1;
	assign push_now   = now_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			level_s1 <= edge_level;
			now_s1   <= time_ext[TIME_BITS-1:0];
		end
	end

endmodule
`default_nettype wire

/* hdl/eibd_queue.sv */
`default_nettype none
module eibd_queue #(
	parameter int WIDTH = 1 + eibd_pkg::TIME_BITS_DEF,
	parameter int DEPTH = eibd_pkg::QUEUE_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire  [WIDTH-1:0]     wr_data,
	input  wire                  pop,
	output logic [WIDTH-1:0]     rd_data,
	output eibd_pkg::q_status_t  q_stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign q_stat.full      = (cnt_q == CNT_W'(DEPTH));
	assign q_stat.not_empty = (cnt_q != '0);
	assign do_push          = push & ~q_stat.full;
	assign do_pop           = pop & q_stat.not_empty;
	assign rd_data          = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

/* hdl/eibd_back.sv */
`default_nettype none
module eibd_back #(
	parameter int MAX_BITS  = eibd_pkg::MAX_BITS_DEF,
	parameter int TIME_BITS = eibd_pkg::TIME_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  wr_en,
	input  wire  [eibd_pkg::CFG_IDX_W-1:0]       wr_index,
	input  wire  [eibd_pkg::CFG_W-1:0]           wr_data,
	input  wire                                  q_valid,
	input  wire                                  q_level,
	input  wire  [TIME_BITS-1:0]                 q_now,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [eibd_pkg::STATUS_W-1:0]        status,
	output logic                                 message_bit,
	output logic [eibd_pkg::IDX_W-1:0]           bit_index,
	output logic                                 is_header,
	output logic [eibd_pkg::OUT_TIME_W-1:0]      interval
);

	localparam int CNT_W = $clog2(MAX_BITS + 1);
	localparam int DEV_W = TIME_BITS + eibd_pkg::DEV_EXTRA_W;
	localparam int THR_W = TIME_BITS + eibd_pkg::END_W;

	// configuration
	logic [eibd_pkg::TOL_W-1:0] tol_q;
	logic [eibd_pkg::END_W-1:0] end_q;

	// decoder state
	logic [TIME_BITS-1:0] last_q;
	logic [TIME_BITS-1:0] fref_q;
	logic [TIME_BITS-1:0] rref_q;
	logic                 aw_f_q;
	logic                 aw_r_q;
	logic                 en_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 thr_stale_q;

	// thresholds, recomputed every cycle from the registered references
	logic [THR_W-1:0] thr_tol_f_q;
	logic [THR_W-1:0] thr_end_f_q;
	logic [THR_W-1:0] thr_tol_r_q;
	logic [THR_W-1:0] thr_end_r_q;

	// result register
	logic                       out_valid_q;
	eibd_pkg::status_t          status_q;
	logic                       bit_q;
	logic [eibd_pkg::IDX_W-1:0] index_q;
	logic                       header_q;
	logic [eibd_pkg::OUT_TIME_W-1:0] interval_q;

	// next-state terms
	logic                 learn_r;
	logic                 learn_f;
	logic                 learned;
	logic                 first_fall;
	logic [TIME_BITS-1:0] rref_n;
	logic [TIME_BITS-1:0] fref_n;
	logic [TIME_BITS-1:0] last_pre;
	logic [TIME_BITS-1:0] last_n;
	logic                 en_n;
	logic                 aw_r_n;
	logic                 aw_f_n;
	logic [TIME_BITS-1:0] ref_sel;
	logic [TIME_BITS-1:0] cur;
	logic [TIME_BITS-1:0] diff;
	logic [DEV_W-1:0]     diff_ext;
	logic [DEV_W-1:0]     dev;
	logic [THR_W-1:0]     dev_ext;
	logic [THR_W-1:0]     thr_tol_sel;
	logic [THR_W-1:0]     thr_end_sel;
	logic                 judge;
	logic                 over_end;
	logic                 over_tol;
	logic                 is_full;
	logic                 accept;
	eibd_pkg::status_t    status_n;
	logic [CNT_W+eibd_pkg::IDX_W-1:0]       cnt_ext;
	logic [TIME_BITS+eibd_pkg::OUT_TIME_W-1:0] cur_ext;

	assign q_pop = q_valid & ~thr_stale_q & (~out_valid_q | ~out_stall);

	always_comb begin
		learn_r    = (rref_q == '0) && !aw_r_q && !q_level;
		learn_f    = aw_f_q && q_level && !aw_r_q;
		learned    = learn_r | learn_f;
		first_fall = aw_r_q && !q_level;
		rref_n     = learn_r ? q_now - last_q : rref_q;
		fref_n     = learn_f ? q_now - last_q : fref_q;
		last_pre   = first_fall ? q_now : last_q;
		en_n       = en_q | learned;
		aw_r_n     = aw_r_q & q_level;
		aw_f_n     = aw_f_q & ~learn_f;

		ref_sel  = q_level ? fref_n : rref_n;
		cur      = q_now - last_pre;
		diff     = (ref_sel > cur) ? ref_sel - cur : cur - ref_sel;
		diff_ext = DEV_W'(diff);
		// times one hundred as 64 + 32 + 4
		dev      = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
		dev_ext  = THR_W'(dev);

		thr_tol_sel = q_level ? thr_tol_f_q : thr_tol_r_q;
		thr_end_sel = q_level ? thr_end_f_q : thr_end_r_q;

		judge = en_n && !aw_r_n && (ref_sel != '0);
		// a freshly learned reference equals the interval, so zero deviation
		over_end = !learned && (dev_ext > thr_end_sel);
		over_tol = !learned && (dev_ext > thr_tol_sel);
		is_full  = (cnt_q == CNT_W'(MAX_BITS));
		accept   = judge && !over_end && !over_tol;
		last_n   = accept ? q_now : last_pre;

		if (!judge) begin
			status_n = eibd_pkg::ST_NONE;
		end else if (over_end) begin
			status_n = eibd_pkg::ST_END;
		end else if (over_tol) begin
			status_n = eibd_pkg::ST_BAD;
		end else if (is_full) begin
			status_n = eibd_pkg::ST_FULL;
		end else begin
			status_n = eibd_pkg::ST_OK;
		end

		cnt_ext = (CNT_W + eibd_pkg::IDX_W)'(cnt_q);
		cur_ext = (TIME_BITS + eibd_pkg::OUT_TIME_W)'(cur);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= eibd_pkg::TOL_RESET;
			end_q       <= eibd_pkg::END_RESET;
			last_q      <= '0;
			fref_q      <= '0;
			rref_q      <= '0;
			aw_f_q      <= 1'b1;
			aw_r_q      <= 1'b1;
			en_q        <= 1'b0;
			cnt_q       <= '0;
			thr_stale_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					eibd_pkg::REG_TOLERANCE: tol_q <= wr_data[eibd_pkg::TOL_W-1:0];
					eibd_pkg::REG_END:       end_q <= wr_data[eibd_pkg::END_W-1:0];
					default: ;
				endcase
			end
			thr_stale_q <= wr_en | (q_pop & learned);
			if (q_pop) begin
				last_q <= last_n;
				fref_q <= fref_n;
				rref_q <= rref_n;
				aw_f_q <= aw_f_n;
				aw_r_q <= aw_r_n;
				en_q   <= en_n;
				if (accept && !is_full) begin
					cnt_q <= cnt_q + 1'b1;
				end
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		thr_tol_f_q <= THR_W'(fref_q) * THR_W'(tol_q);
		thr_end_f_q <= THR_W'(fref_q) * THR_W'(end_q);
		thr_tol_r_q <= THR_W'(rref_q) * THR_W'(tol_q);
		thr_end_r_q <= THR_W'(rref_q) * THR_W'(end_q);
		if (q_pop) begin
			status_q   <= status_n;
			bit_q      <= accept & ~q_level;
			index_q    <= (status_n == eibd_pkg::ST_OK) ?
				cnt_ext[eibd_pkg::IDX_W-1:0] : '0;
			header_q   <= (status_n == eibd_pkg::ST_OK) && (cnt_q < CNT_W'(2));
			interval_q <= cur_ext[eibd_pkg::OUT_TIME_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign message_bit = bit_q;
	assign bit_index   = index_q;
	assign is_header   = header_q;
	assign interval    = interval_q;

endmodule
`default_nettype wire

/* hdl/edge_interval_bit_decoder.sv */
// edge interval bit decoder
// input channel: one request per line edge, edge_level (level after the edge)
//   and edge_time (free-running tick count), taken when in_valid is high and
//   in_stall is low
// output channel: exactly one result request per edge (status, message_bit,
//   bit_index, is_header, interval), taken when out_valid is high and
//   out_stall is low
// config: wr_en with wr_index 0 writes tolerance_percent, 1 writes end_percent;
//   write only while the block is idle
// latency: three cycles from input to output (input stage, queue, result reg)
// throughput: one edge per cycle; the cycle after a reference is learned or a
//   config write lands, the back end waits one cycle while the threshold
//   products (reference times percent) are registered
// stall: a stalled result holds in the output register; the two-entry queue
//   and input stage keep accepting until they fill, then in_stall rises
// reset: references and last edge time clear, timing waits for the first
//   falling edge, bit count clears, registers return to 25 and 300 percent
`default_nettype none
module edge_interval_bit_decoder #(
	parameter int MAX_BITS  = eibd_pkg::MAX_BITS_DEF,
	parameter int TIME_BITS = eibd_pkg::TIME_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	// config write port
	input  wire                               wr_en,
	input  wire  [eibd_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire  [eibd_pkg::CFG_W-1:0]        wr_data,
	// edge requests
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire                               edge_level,
	input  wire  [eibd_pkg::IN_TIME_W-1:0]    edge_time,
	// result requests
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic [eibd_pkg::STATUS_W-1:0]     status,
	output logic                              message_bit,
	output logic [eibd_pkg::IDX_W-1:0]        bit_index,
	output logic                              is_header,
	output logic [eibd_pkg::OUT_TIME_W-1:0]   interval
);

	localparam int Q_W = 1 + TIME_BITS;

	// front to queue
	eibd_pkg::q_status_t  q_stat;
	logic                 push;
	logic                 push_level;
	logic [TIME_BITS-1:0] push_now;

	// queue to back
	logic                 q_pop;
	logic [Q_W-1:0]       q_rd;

	// front: takes edges and folds the timestamp into the time domain
	eibd_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.edge_level (edge_level),
		.edge_time  (edge_time),
		.q_stat     (q_stat),
		.push       (push),
		.push_level (push_level),
		.push_now   (push_now)
	);

	// short queue so front and back stall independently
	eibd_queue #(
		.WIDTH (Q_W),
		.DEPTH (eibd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data ({push_level, push_now}),
		.pop     (q_pop),
		.rd_data (q_rd),
		.q_stat  (q_stat)
	);

	// back: learns references, judges intervals, emits bits
	eibd_back #(
		.MAX_BITS  (MAX_BITS),
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.q_valid     (q_stat.not_empty),
		.q_level     (q_rd[Q_W-1]),
		.q_now       (q_rd[TIME_BITS-1:0]),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.message_bit (message_bit),
		.bit_index   (bit_index),
		.is_header   (is_header),
		.interval    (interval)
	);

endmodule
`default_nettype wire
